// ----- sv/midpoint_circle_rasterizer_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the midpoint circle rasterizer
// Shared concurrent assertion wrappers, clocked on clk with reset rst_n.
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_CIRCLE_RASTERIZER_MACROS_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_MACROS_SVH

// Property that must hold in the same cycle as its antecedent.
`define MCR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Property that must hold in the cycle after its antecedent.
`define MCR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/mcr_pkg.sv -----
// ----------------------------------------------------------------------------
// mcr_pkg
// Types and constants shared by the circle rasterizer front, queue and back.
// ----------------------------------------------------------------------------
package mcr_pkg;

    // Item operation codes.
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Default screen size and command queue depth.
    localparam int SCREEN_WIDTH_DEF  = 240;
    localparam int SCREEN_HEIGHT_DEF = 320;
    localparam int QUEUE_DEPTH_DEF   = 2;

    // Points per step and the width of the point counter.
    localparam int POINTS = 8;
    localparam int IDX_W  = 3;

    // Field widths.
    localparam int CTR_W   = 10;
    localparam int PT_W    = 11;
    localparam int DEC_W   = 16;
    localparam int COLOR_W = 16;
    localparam int COORD_W = 13;
    localparam int PX_W    = 8;
    localparam int PY_W    = 9;

    // One queued step command: a snapshot of the iteration to draw.
    typedef struct packed {
        logic                     done;
        logic [CTR_W-1:0]         ctr_x;
        logic [CTR_W-1:0]         ctr_y;
        logic signed [PT_W-1:0]   pt_x;
        logic signed [PT_W-1:0]   pt_y;
        logic [COLOR_W-1:0]       color;
    } cmd_t;

    // Queue occupancy flags seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ----- sv/mcr_front.sv -----
// ----------------------------------------------------------------------------
// mcr_front
// Accepts items, holds the circle iteration state and queues step commands.
// ----------------------------------------------------------------------------
module mcr_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                op,
    input  logic [9:0]          cx,
    input  logic [9:0]          cy,
    input  logic [9:0]          radius,
    input  logic [15:0]         color_in,
    input  mcr_pkg::q_status_t  q_status,
    output logic                push,
    output mcr_pkg::cmd_t       cmd
);
    import mcr_pkg::*;

    logic [CTR_W-1:0]       ctr_x_reg,    ctr_x_next;
    logic [CTR_W-1:0]       ctr_y_reg,    ctr_y_next;
    logic [COLOR_W-1:0]     color_reg,    color_next;
    logic signed [PT_W-1:0] cur_x_reg,    cur_x_next;
    logic signed [PT_W-1:0] cur_y_reg,    cur_y_next;
    logic [DEC_W-1:0]       decision_reg, decision_next;
    logic                   busy_reg,     busy_next;

    logic             accept;
    logic             done;
    logic [DEC_W-1:0] x_ext;
    logic [DEC_W-1:0] y_ext;

    // A transaction is taken whenever the queue has room for a command.
    assign in_stall = q_status.full;
    assign accept   = in_valid && !in_stall;

    // A step is finished when no circle is active or the octant is complete.
    assign done = !busy_reg || (cur_x_reg > cur_y_reg);

    // Every accepted step pushes one command, finished or not.
    assign push       = accept && (op == OP_STEP);
    assign cmd.done   = done;
    assign cmd.ctr_x  = ctr_x_reg;
    assign cmd.ctr_y  = ctr_y_reg;
    assign cmd.pt_x   = cur_x_reg;
    assign cmd.pt_y   = cur_y_reg;
    assign cmd.color  = color_reg;

    assign x_ext = DEC_W'(cur_x_reg);
    assign y_ext = DEC_W'(cur_y_reg);

    // Load a new circle on start, advance the midpoint iteration on step.
    always_comb
    begin
        ctr_x_next    = ctr_x_reg;
        ctr_y_next    = ctr_y_reg;
        color_next    = color_reg;
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        decision_next = decision_reg;
        busy_next     = busy_reg;
        if (accept)
        begin
            if (op == OP_START)
            begin
                ctr_x_next    = cx;
                ctr_y_next    = cy;
                color_next    = color_in;
                cur_x_next    = '0;
                cur_y_next    = $signed({1'b0, radius});
                decision_next = DEC_W'(3) - {5'b0, radius, 1'b0};
                busy_next     = 1'b1;
            end
            else if (!done)
            begin
                if (decision_reg[DEC_W-1])
                begin
                    decision_next = decision_reg + {x_ext[DEC_W-3:0], 2'b00} + DEC_W'(6);
                end
                else
                begin
                    decision_next = decision_reg + {x_ext[DEC_W-3:0] - y_ext[DEC_W-3:0], 2'b00}
                                    + DEC_W'(10);
                    cur_y_next    = cur_y_reg - PT_W'(1);
                end
                cur_x_next = cur_x_reg + PT_W'(1);
            end
        end
    end

    // Circle state registers; reset leaves no circle active.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctr_x_reg    <= '0;
            ctr_y_reg    <= '0;
            color_reg    <= '0;
            cur_x_reg    <= '0;
            cur_y_reg    <= '0;
            decision_reg <= '0;
            busy_reg     <= 1'b0;
        end
        else
        begin
            ctr_x_reg    <= ctr_x_next;
            ctr_y_reg    <= ctr_y_next;
            color_reg    <= color_next;
            cur_x_reg    <= cur_x_next;
            cur_y_reg    <= cur_y_next;
            decision_reg <= decision_next;
            busy_reg     <= busy_next;
        end
    end

endmodule

// ----- sv/mcr_queue.sv -----
// ----------------------------------------------------------------------------
// mcr_queue
// Short first-in first-out queue of step commands between front and back.
// ----------------------------------------------------------------------------
module mcr_queue #(
    parameter int DEPTH = mcr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mcr_pkg::cmd_t       push_cmd,
    input  logic                pop,
    output mcr_pkg::cmd_t       head,
    output mcr_pkg::q_status_t  q_status
);
    import mcr_pkg::*;

    `include "midpoint_circle_rasterizer_macros.svh"

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign q_status.full  = (count_reg == CNT_W'(DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign head           = entry_reg[rd_ptr_reg];

    // Pointer and occupancy update with wrap at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (!push && pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Command storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `MCR_ASSERT_SAME(a_no_push_full, push, !q_status.full, "push into a full queue")
    `MCR_ASSERT_SAME(a_no_pop_empty, pop, !q_status.empty, "pop from an empty queue")
    `MCR_ASSERT_SAME(a_count_range, 1'b1, count_reg <= CNT_W'(DEPTH), "queue count overflow")

endmodule

// ----- sv/mcr_back.sv -----
// ----------------------------------------------------------------------------
// mcr_back
// Expands steps into eight points (one if finished), one a cycle unless stalled.
// ----------------------------------------------------------------------------
module mcr_back #(
    parameter int SCREEN_WIDTH  = mcr_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = mcr_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mcr_pkg::cmd_t       head,
    input  mcr_pkg::q_status_t  q_status,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          px,
    output logic [8:0]          py,
    output logic                visible,
    output logic [15:0]         pixel_color,
    output logic                last,
    output logic                done_res
);
    import mcr_pkg::*;

    `include "midpoint_circle_rasterizer_macros.svh"

    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic                      out_valid_reg, out_valid_next;
    logic [PX_W-1:0]           px_reg;
    logic [PY_W-1:0]           py_reg;
    logic                      visible_reg;
    logic [COLOR_W-1:0]        color_reg;
    logic                      last_reg;
    logic                      done_reg;

    logic                      load;
    logic                      fire;
    logic                      last_point;
    logic signed [PT_W-1:0]    a_off;
    logic signed [PT_W-1:0]    b_off;
    logic signed [COORD_W-1:0] a_ext;
    logic signed [COORD_W-1:0] b_ext;
    logic signed [COORD_W-1:0] col;
    logic signed [COORD_W-1:0] row;
    logic                      on_screen;

    // The output register takes a new point whenever it is empty or drained.
    assign load       = !out_valid_reg || !out_stall;
    assign fire       = load && !q_status.empty;
    assign last_point = head.done || (idx_reg == IDX_W'(POINTS - 1));
    assign pop        = fire && last_point;

    // Point order: bit 2 swaps the axes, bit 1 negates the column, bit 0 the row.
    assign a_off = idx_reg[2] ? head.pt_y : head.pt_x;
    assign b_off = idx_reg[2] ? head.pt_x : head.pt_y;
    assign a_ext = COORD_W'(a_off);
    assign b_ext = COORD_W'(b_off);
    assign col   = $signed(COORD_W'(head.ctr_x)) + (idx_reg[1] ? -a_ext : a_ext);
    assign row   = $signed(COORD_W'(head.ctr_y)) + (idx_reg[0] ? -b_ext : b_ext);

    // Screen clip: both coordinates non-negative and below the screen size.
    assign on_screen = !col[COORD_W-1] && !row[COORD_W-1]
                       && (col < $signed(COORD_W'(SCREEN_WIDTH)))
                       && (row < $signed(COORD_W'(SCREEN_HEIGHT)));

    // Point counter walks the eight octants and restarts with each command.
    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = fire;
        end
        if (fire)
        begin
            idx_next = last_point ? '0 : idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            visible_reg <= !head.done && on_screen;
            px_reg      <= (!head.done && on_screen) ? col[PX_W-1:0] : '0;
            py_reg      <= (!head.done && on_screen) ? row[PY_W-1:0] : '0;
            color_reg   <= head.color;
            last_reg    <= last_point;
            done_reg    <= head.done;
        end
    end

    assign out_valid   = out_valid_reg;
    assign px          = px_reg;
    assign py          = py_reg;
    assign visible     = visible_reg;
    assign pixel_color = color_reg;
    assign last        = last_reg;
    assign done_res    = done_reg;

    `MCR_ASSERT_SAME(a_mid_cmd_present, idx_reg != '0, !q_status.empty,
                     "point counter running without a queued command")
    `MCR_ASSERT_SAME(a_done_is_last, out_valid && done_res, last && !visible,
                     "finished step result must be single and invisible")
    `MCR_ASSERT_NEXT(a_restart_after_last, fire && last_point, idx_reg == '0,
                     "point counter did not restart after the last point")

endmodule

// ----- sv/midpoint_circle_rasterizer.sv -----
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer
// Midpoint circle outline generator with a clipped eight-point result stream.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): op = start loads cx, cy, radius and
// color_in and gives no result; op = step draws one iteration of the circle.
// Output channel (out_valid / out_stall): one point per transaction with its
// visible flag, color, last marker and done_res flag.
// A step on an active circle gives eight points, last set on the eighth; a
// step on a finished or absent circle gives one invisible point with last
// and done_res set.
// With the back end idle, the first point of a step passes from the queue
// entry into the output register. The back end issues one point per cycle
// through a single output register while out_stall is low. Start items do
// not enter the queue.
// A queue of QUEUE_DEPTH step commands sits between the front end and the
// back end; input is accepted until it is full, while results wait.
// When out_stall is high the current point holds and the back end pauses.
// Reset clears the queue, the output register and the circle state, leaving
// no circle active.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer #(
    parameter int SCREEN_WIDTH  = mcr_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = mcr_pkg::SCREEN_HEIGHT_DEF,
    parameter int QUEUE_DEPTH   = mcr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [9:0]  cx,
    input  logic [9:0]  cy,
    input  logic [9:0]  radius,
    input  logic [15:0] color_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  px,
    output logic [8:0]  py,
    output logic        visible,
    output logic [15:0] pixel_color,
    output logic        last,
    output logic        done_res
);
    import mcr_pkg::*;

    cmd_t      push_cmd;
    cmd_t      head;
    q_status_t q_status;
    logic      push;
    logic      pop;

    // Front end: item acceptance and circle iteration state.
    mcr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .op       (op),
        .cx       (cx),
        .cy       (cy),
        .radius   (radius),
        .color_in (color_in),
        .q_status (q_status),
        .push     (push),
        .cmd      (push_cmd)
    );

    // Step command queue.
    mcr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .q_status (q_status)
    );

    // Back end: point expansion, clipping and output register.
    mcr_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_status    (q_status),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .px          (px),
        .py          (py),
        .visible     (visible),
        .pixel_color (pixel_color),
        .last        (last),
        .done_res    (done_res)
    );

endmodule

// ----- bench/mcr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circle rasterizer scoreboard
// Watches both channels of the rasterizer. It keeps its own copy of the
// circle state, works out the points that each accepted step must produce,
// and compares every accepted result field by field, oldest first.
// ----------------------------------------------------------------------------
module mcr_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        op,
    input  logic [9:0]  cx,
    input  logic [9:0]  cy,
    input  logic [9:0]  radius,
    input  logic [15:0] color_in,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  px,
    input  logic [8:0]  py,
    input  logic        visible,
    input  logic [15:0] pixel_color,
    input  logic        last,
    input  logic        done_res,
    output int          fail_count,
    output int          pending,
    output int          points_seen,
    output int          visible_seen,
    output int          done_seen
);
    import mcr_pkg::*;

    localparam int SCREEN_W = SCREEN_WIDTH_DEF;
    localparam int SCREEN_H = SCREEN_HEIGHT_DEF;

    // One predicted point as it should leave the output channel.
    typedef struct packed {
        logic [PX_W-1:0]    px;
        logic [PY_W-1:0]    py;
        logic               visible;
        logic [COLOR_W-1:0] color;
        logic               last;
        logic               done;
    } pixel_t;

    pixel_t pixel_queue[$];

    // Shadow copy of the circle being traced.
    logic [CTR_W-1:0]        ctr_x_q    = '0;
    logic [CTR_W-1:0]        ctr_y_q    = '0;
    logic [COLOR_W-1:0]      color_q    = '0;
    logic signed [PT_W-1:0]  pt_x_q     = '0;
    logic signed [PT_W-1:0]  pt_y_q     = '0;
    logic signed [DEC_W-1:0] decision_q = '0;
    logic                    active_q   = 1'b0;

    int errors    = 0;
    int n_points  = 0;
    int n_visible = 0;
    int n_done    = 0;

    // Clip one point against the screen; off-screen points read as zero.
    function automatic pixel_t clip_point(int col, int row, logic is_last);
        pixel_t p;
        p = '0;
        p.visible = (col >= 0) && (col < SCREEN_W) && (row >= 0) && (row < SCREEN_H);
        p.px      = p.visible ? col[PX_W-1:0] : '0;
        p.py      = p.visible ? row[PY_W-1:0] : '0;
        p.color   = color_q;
        p.last    = is_last;
        return p;
    endfunction

    // Predict one step transaction and advance the midpoint iteration.
    task automatic trace_step();
        int x;
        int y;
        int d;
        int ox;
        int oy;
        pixel_t finished;
        x = pt_x_q;
        y = pt_y_q;
        if (!active_q || x > y)
        begin
            // Nothing left to draw: a single invisible marker.
            finished       = '0;
            finished.color = color_q;
            finished.last  = 1'b1;
            finished.done  = 1'b1;
            pixel_queue.push_back(finished);
        end
        else
        begin
            ox = ctr_x_q;
            oy = ctr_y_q;
            pixel_queue.push_back(clip_point(ox + x, oy + y, 1'b0));
            pixel_queue.push_back(clip_point(ox + x, oy - y, 1'b0));
            pixel_queue.push_back(clip_point(ox - x, oy + y, 1'b0));
            pixel_queue.push_back(clip_point(ox - x, oy - y, 1'b0));
            pixel_queue.push_back(clip_point(ox + y, oy + x, 1'b0));
            pixel_queue.push_back(clip_point(ox + y, oy - x, 1'b0));
            pixel_queue.push_back(clip_point(ox - y, oy + x, 1'b0));
            pixel_queue.push_back(clip_point(ox - y, oy - x, 1'b1));
            // Midpoint decision update, kept at the register widths.
            d = decision_q;
            if (d < 0)
            begin
                d = d + x * 4 + 6;
            end
            else
            begin
                d = d + (x - y) * 4 + 10;
                y = y - 1;
            end
            x = x + 1;
            decision_q = d[DEC_W-1:0];
            pt_x_q     = x[PT_W-1:0];
            pt_y_q     = y[PT_W-1:0];
        end
    endtask

    task automatic compare_field(string field, int want, int got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    // Both channels are sampled at the rising edge, before any update lands.
    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        pixel_t want;
        if (!rst_n)
        begin
            ctr_x_q    = '0;
            ctr_y_q    = '0;
            color_q    = '0;
            pt_x_q     = '0;
            pt_y_q     = '0;
            decision_q = '0;
            active_q   = 1'b0;
            pixel_queue.delete();
            pending    <= 0;
        end
        else
        begin
            // Input side: a start loads the circle, a step predicts points.
            if (in_valid && !in_stall)
            begin
                if (op == OP_START)
                begin
                    ctr_x_q    = cx;
                    ctr_y_q    = cy;
                    color_q    = color_in;
                    pt_x_q     = '0;
                    pt_y_q     = PT_W'(radius);
                    decision_q = DEC_W'(3 - 2 * int'(radius));
                    active_q   = 1'b1;
                end
                else
                begin
                    trace_step();
                end
            end

            // Output side: match against the oldest prediction.
            if (out_valid && !out_stall)
            begin
                n_points++;
                n_visible += visible;
                n_done    += done_res;
                if (pixel_queue.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual px=%0d py=%0d",
                             $time, px, py);
                end
                else
                begin
                    want = pixel_queue.pop_front();
                    compare_field("px", want.px, px);
                    compare_field("py", want.py, py);
                    compare_field("visible", want.visible, visible);
                    compare_field("pixel_color", want.color, pixel_color);
                    compare_field("last", want.last, last);
                    compare_field("done_res", want.done, done_res);
                end
            end

            pending      <= pixel_queue.size();
            fail_count   <= errors;
            points_seen  <= n_points;
            visible_seen <= n_visible;
            done_seen    <= n_done;
        end
    end

endmodule

// ----- bench/midpoint_circle_rasterizer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circle rasterizer testbench
// Drives start and step transactions into the rasterizer in random bursts,
// stalls the result channel on its own pattern, and leaves all prediction
// and comparison to the scoreboard beside the block.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer_tb;
    import mcr_pkg::*;

    localparam int RANDOM_ITEMS = 270;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 120;
    localparam int DRAIN_CYCLES = 20;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        op        = OP_STEP;
    logic [9:0]  cx        = '0;
    logic [9:0]  cy        = '0;
    logic [9:0]  radius    = '0;
    logic [15:0] color_in  = '0;
    logic        out_stall = 1'b0;

    logic        in_stall;
    logic        out_valid;
    logic [7:0]  px;
    logic [8:0]  py;
    logic        visible;
    logic [15:0] pixel_color;
    logic        last;
    logic        done_res;

    int fail_count;
    int pending;
    int points_seen;
    int visible_seen;
    int done_seen;

    int cycle_count     = 0;
    int items_sent      = 0;
    int circles_started = 0;
    int burst_left      = 0;
    bit hold_req        = 1'b0;

    midpoint_circle_rasterizer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .cx          (cx),
        .cy          (cy),
        .radius      (radius),
        .color_in    (color_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .px          (px),
        .py          (py),
        .visible     (visible),
        .pixel_color (pixel_color),
        .last        (last),
        .done_res    (done_res)
    );

    mcr_checker scoreboard (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .cx           (cx),
        .cy           (cy),
        .radius       (radius),
        .color_in     (color_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .px           (px),
        .py           (py),
        .visible      (visible),
        .pixel_color  (pixel_color),
        .last         (last),
        .done_res     (done_res),
        .fail_count   (fail_count),
        .pending      (pending),
        .points_seen  (points_seen),
        .visible_seen (visible_seen),
        .done_seen    (done_seen)
    );

    // Clock with a 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Offer one transaction and hold it until accepted; bursts and gaps vary.
    task automatic send_item(input logic kind, input logic [9:0] col, input logic [9:0] row,
                             input logic [9:0] rad, input logic [15:0] hue);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        in_valid <= 1'b1;
        op       <= kind;
        cx       <= col;
        cy       <= row;
        radius   <= rad;
        color_in <= hue;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic start_circle(input logic [9:0] col, input logic [9:0] row,
                                input logic [9:0] rad, input logic [15:0] hue);
        circles_started++;
        send_item(OP_START, col, row, rad, hue);
    endtask

    // Step transactions carry junk in the fields they do not use.
    task automatic step_circle();
        send_item(OP_STEP, 10'($urandom), 10'($urandom), 10'($urandom), 16'($urandom));
    endtask

    // Stop offering and wait until every predicted point has come out.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Receiver: phases of free flow, light and heavy stalls, a fixed pattern,
    // and a long hold-off whenever the stimulus asks for one.
    initial
    begin
        int mode;
        int span;
        int k;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 120);
            for (k = 0; k < span && !hold_req; k++)
            begin
                @(posedge clk);
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 9) < 7);
                    default: out_stall <= (k % 3 == 2);
                endcase
            end
            if (hold_req)
            begin
                hold_req = 1'b0;
                for (k = 0; k < LONG_HOLD; k++)
                begin
                    @(posedge clk);
                    out_stall <= 1'b1;
                end
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        int steps;
        int rad;
        int base;
        int holds_asked;
        bit mid_drain_done;
        logic [9:0] col;
        logic [9:0] row;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: step with no circle, zero radius, full-scale fields,
        // a circle inside the screen, and circles clipped at each edge.
        step_circle();
        start_circle(10'd0, 10'd0, 10'd0, 16'h0000);
        step_circle();
        step_circle();
        start_circle(10'd1023, 10'd1023, 10'd1023, 16'hFFFF);
        step_circle();
        step_circle();
        start_circle(10'd120, 10'd160, 10'd5, 16'hF800);
        repeat (6) step_circle();
        start_circle(10'd2, 10'd3, 10'd10, 16'h07E0);
        repeat (3) step_circle();
        start_circle(10'd239, 10'd319, 10'd1, 16'h001F);
        repeat (2) step_circle();
        wait_drained();

        // Random: mostly whole circles traced to the end, some noise.
        base           = items_sent;
        holds_asked    = 0;
        mid_drain_done = 1'b0;
        while (items_sent - base < RANDOM_ITEMS)
        begin
            if ((holds_asked == 0 && items_sent - base >= 30) ||
                (holds_asked == 1 && items_sent - base >= 180))
            begin
                hold_req = 1'b1;
                holds_asked++;
            end
            if (!mid_drain_done && items_sent - base >= 130)
            begin
                wait_drained();
                mid_drain_done = 1'b1;
            end

            if ($urandom_range(0, 99) < 85)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    col = 10'($urandom);
                    row = 10'($urandom);
                end
                else
                begin
                    col = 10'($urandom_range(0, 259));
                    row = 10'($urandom_range(0, 339));
                end
                rad = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                                   : $urandom_range(0, 24);
                steps = (rad > 40) ? $urandom_range(1, 6) : rad * 3 / 4 + $urandom_range(1, 3);
                start_circle(col, row, 10'(rad), 16'($urandom));
                repeat (steps) step_circle();
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                step_circle();
            end
            else
            begin
                start_circle(10'($urandom), 10'($urandom), 10'($urandom), 16'($urandom));
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d transactions, %0d of them circle starts.", items_sent, circles_started);
        $display("Checked %0d points: %0d on screen, %0d end-of-circle markers.",
                 points_seen, visible_seen, done_seen);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/mcr_pkg.sv
sv/mcr_front.sv
sv/mcr_queue.sv
sv/mcr_back.sv
sv/midpoint_circle_rasterizer.sv
bench/mcr_checker.sv
bench/midpoint_circle_rasterizer_tb.sv
